// ===== hw/rtl/msort_pkg.sv =====
// ----------------------------------------------------------------------------
// msort_pkg
// Shared types and defaults for the merge sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package msort_pkg;

  localparam int VALUE_WIDTH     = 32;
  localparam int DEF_MAX_ITEMS   = 64;
  localparam int DEF_DATA_WIDTH  = 32;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PRIME,
    ST_MERGE,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/msort_ram.sv =====
// ----------------------------------------------------------------------------
// msort_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output      logic [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output      logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/merge_sort_engine.sv =====
// ----------------------------------------------------------------------------
// merge_sort_engine
// Stable bottom-up merge sort of one set of signed words, two RAM banks.
// ----------------------------------------------------------------------------
// Usage:
//   Load: drive value and last_item with start; a word is taken on a rising
//   edge with start high and busy low, one word per cycle. Words past
//   MAX_ITEMS are dropped and flag overflowed on every result of the set.
//   Sort: the word marked last_item raises busy. Each merge pass streams the
//   set from one RAM bank to the other at one word per cycle, using both
//   read ports of the source bank for the two run heads. Each pass opens
//   with a prime step; there are ceil(log2(n)) passes.
//   Emit: n results follow at one per cycle, each shown for one cycle with
//   strobe high; the final one carries last_out. The receiver cannot stall.
//   The first result appears once the last pass is done; busy falls with
//   the read of the final result, so a new set may load while that result
//   is still on the ports.
//   A new set is taken only once busy falls; the merge passes are bound
//   by the single write port of the destination bank.
//   Reset: rst clears the control state; the block comes up ready to load.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sort_engine
  import msort_pkg::*;
#(
  parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  input  wire logic                          last_item,
  output      logic                          strobe,
  output      logic signed [VALUE_WIDTH-1:0] sorted_value,
  output      logic                          last_out,
  output      logic                          overflowed
);

  localparam int SW = (DATA_WIDTH < VALUE_WIDTH) ? DATA_WIDTH : VALUE_WIDTH;
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int EW = CW + 2;
  localparam logic [CW-1:0] MAXC = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] TWO  = CW'(2);

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic          drop, drop_next;
  logic [CW-1:0] rw, rw_next;
  logic [CW-1:0] lp, lp_next;
  logic [CW-1:0] rp, rp_next;
  logic [CW-1:0] wp, wp_next;
  logic [CW-1:0] seg_mid, seg_mid_next;
  logic [CW-1:0] seg_end, seg_end_next;
  logic [CW-1:0] k, k_next;
  logic          src, src_next;
  logic          strobe_next, last_next, over_next;

  logic          wen0, wen1;
  logic [AW-1:0] waddr, ra, rb;
  logic [SW-1:0] wdata;
  logic [SW-1:0] q0a, q0b, q1a, q1b;
  logic signed [SW-1:0] qa, qb;

  logic [EW-1:0] n_w, rw_w, mid0_w, end0_w, ns_mid_w, ns_end_w, rw2_w;
  logic          take_left;

  msort_ram #(.WIDTH(SW), .DEPTH(MAX_ITEMS)) u_bank0 (
    .clk(clk), .we(wen0), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .rdata_a(q0a), .raddr_b(rb), .rdata_b(q0b)
  );

  msort_ram #(.WIDTH(SW), .DEPTH(MAX_ITEMS)) u_bank1 (
    .clk(clk), .we(wen1), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .rdata_a(q1a), .raddr_b(rb), .rdata_b(q1b)
  );

  assign qa           = signed'(src ? q1a : q0a);
  assign qb           = signed'(src ? q1b : q0b);
  assign sorted_value = VALUE_WIDTH'(qa);
  assign busy         = (state != ST_LOAD);

  assign n_w      = EW'(count);
  assign rw_w     = EW'(rw);
  assign rw2_w    = rw_w << 1;
  assign mid0_w   = (rw_w < n_w) ? rw_w : n_w;
  assign end0_w   = (rw2_w < n_w) ? rw2_w : n_w;
  assign ns_mid_w = ((EW'(seg_end) + rw_w) < n_w) ? (EW'(seg_end) + rw_w) : n_w;
  assign ns_end_w = ((EW'(seg_end) + rw2_w) < n_w) ? (EW'(seg_end) + rw2_w) : n_w;

  always_comb begin
    if (lp >= seg_mid) begin
      take_left = 1'b0;
    end else if (rp >= seg_end) begin
      take_left = 1'b1;
    end else begin
      take_left = (qa <= qb);
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    drop_next    = drop;
    rw_next      = rw;
    lp_next      = lp;
    rp_next      = rp;
    wp_next      = wp;
    seg_mid_next = seg_mid;
    seg_end_next = seg_end;
    k_next       = k;
    src_next     = src;
    strobe_next  = 1'b0;
    last_next    = 1'b0;
    over_next    = overflowed;
    wen0         = 1'b0;
    wen1         = 1'b0;
    waddr        = wp[AW-1:0];
    wdata        = take_left ? qa : qb;
    ra           = lp[AW-1:0];
    rb           = rp[AW-1:0];
    case (state)
      ST_LOAD: begin
        if (start) begin
          if (count < MAXC) begin
            wen0       = 1'b1;
            waddr      = count[AW-1:0];
            wdata      = value[SW-1:0];
            count_next = count + ONE;
          end else begin
            drop_next = 1'b1;
          end
          if (last_item) begin
            src_next = 1'b0;
            rw_next  = ONE;
            k_next   = '0;
            if (count_next < TWO) begin
              state_next = ST_EMIT;
            end else begin
              state_next = ST_PRIME;
            end
          end
        end
      end
      ST_PRIME: begin
        lp_next      = '0;
        rp_next      = mid0_w[CW-1:0];
        wp_next      = '0;
        seg_mid_next = mid0_w[CW-1:0];
        seg_end_next = end0_w[CW-1:0];
        ra           = '0;
        rb           = mid0_w[AW-1:0];
        state_next   = ST_MERGE;
      end
      ST_MERGE: begin
        wen0    = src;
        wen1    = !src;
        lp_next = take_left ? lp + ONE : lp;
        rp_next = take_left ? rp : rp + ONE;
        wp_next = wp + ONE;
        ra      = lp_next[AW-1:0];
        rb      = rp_next[AW-1:0];
        if (wp_next == seg_end) begin
          if (seg_end < count) begin
            lp_next      = seg_end;
            rp_next      = ns_mid_w[CW-1:0];
            seg_mid_next = ns_mid_w[CW-1:0];
            seg_end_next = ns_end_w[CW-1:0];
            ra           = seg_end[AW-1:0];
            rb           = ns_mid_w[AW-1:0];
          end else begin
            rw_next  = rw2_w[CW-1:0];
            src_next = !src;
            k_next   = '0;
            if (rw2_w >= n_w) begin
              state_next = ST_EMIT;
            end else begin
              state_next = ST_PRIME;
            end
          end
        end
      end
      ST_EMIT: begin
        ra          = k[AW-1:0];
        strobe_next = 1'b1;
        last_next   = (k == count - ONE);
        over_next   = drop;
        k_next      = k + ONE;
        if (k == count - ONE) begin
          state_next = ST_LOAD;
          count_next = '0;
          drop_next  = 1'b0;
          rw_next    = ONE;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      drop       <= 1'b0;
      rw         <= ONE;
      k          <= '0;
      src        <= 1'b0;
      strobe     <= 1'b0;
      last_out   <= 1'b0;
      overflowed <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      drop       <= drop_next;
      rw         <= rw_next;
      k          <= k_next;
      src        <= src_next;
      strobe     <= strobe_next;
      last_out   <= last_next;
      overflowed <= over_next;
    end
  end

  always_ff @(posedge clk) begin
    lp      <= lp_next;
    rp      <= rp_next;
    wp      <= wp_next;
    seg_mid <= seg_mid_next;
    seg_end <= seg_end_next;
  end

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == ST_EMIT)
    else $error("result strobe without an emit read");

  a_set_boundary: assert property (@(posedge clk) disable iff (rst)
    strobe && last_out |=> !strobe)
    else $error("result after the final word of a set");

  a_merge_window: assert property (@(posedge clk) disable iff (rst)
    state == ST_MERGE |-> wp < seg_end && seg_end <= count)
    else $error("merge write outside its segment");

  a_merge_heads: assert property (@(posedge clk) disable iff (rst)
    state == ST_MERGE |-> lp <= seg_mid && rp <= seg_end && seg_mid <= rp)
    else $error("merge run head out of range");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= MAXC)
    else $error("word count beyond capacity");

endmodule

`default_nettype wire
